>>> rtl/core/ssh128_pkg.sv
package ssh128_pkg;

    // Default configuration values for the top-level parameters.
    localparam int LENGTH_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Seed constant of the short hash.
    localparam logic [63:0] SEED_MAGIC = 64'hdeadbeefdeadbeef;

    // The mix and end functions both run in six steps of at most two rounds.
    localparam logic [2:0] STEP_LAST = 3'd5;

    // Input transaction: one message word.
    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
        logic [31:0] total_length;
    } in_item_t;

    // Output transaction: the 128-bit hash.
    typedef struct packed {
        logic [63:0] hash_low;
        logic [63:0] hash_high;
    } out_item_t;

    // What the back end does with a word.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD_A,
        OP_ADD_B,
        OP_ADD_C,
        OP_ADD_D,
        OP_ADD_D_MIX
    } op_t;

    // One classified word as it travels from the front end to the back end.
    typedef struct packed {
        op_t         op;
        logic [63:0] word;
        logic        last;
        logic [7:0]  len_byte;
        logic        tail_empty;
    } q_entry_t;

    // The four hash accumulators.
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } acc_t;

    localparam acc_t ACC_RESET = '{a: 64'd0, b: 64'd0, c: SEED_MAGIC, d: SEED_MAGIC};

    // Rotate left by a constant amount.
    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
        return (x << k) | (x >> (64 - k));
    endfunction

    // Single rounds of the short mix.
    function automatic acc_t mix_rc(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.c = rotl(r.c, k);
        r.c = r.c + r.d;
        r.a = r.a ^ r.c;
        return r;
    endfunction

    function automatic acc_t mix_rd(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.d = rotl(r.d, k);
        r.d = r.d + r.a;
        r.b = r.b ^ r.d;
        return r;
    endfunction

    function automatic acc_t mix_ra(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.a = rotl(r.a, k);
        r.a = r.a + r.b;
        r.c = r.c ^ r.a;
        return r;
    endfunction

    function automatic acc_t mix_rb(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.b = rotl(r.b, k);
        r.b = r.b + r.c;
        r.d = r.d ^ r.b;
        return r;
    endfunction

    // Single rounds of the short end function.
    function automatic acc_t end_r0(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.d = r.d ^ r.c;
        r.c = rotl(r.c, k);
        r.d = r.d + r.c;
        return r;
    endfunction

    function automatic acc_t end_r1(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.a = r.a ^ r.d;
        r.d = rotl(r.d, k);
        r.a = r.a + r.d;
        return r;
    endfunction

    function automatic acc_t end_r2(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.b = r.b ^ r.a;
        r.a = rotl(r.a, k);
        r.b = r.b + r.a;
        return r;
    endfunction

    function automatic acc_t end_r3(input acc_t s, input int unsigned k);
        acc_t r;
        r = s;
        r.c = r.c ^ r.b;
        r.b = rotl(r.b, k);
        r.c = r.c + r.b;
        return r;
    endfunction

    // Two rounds of the 12-round mix per step.
    function automatic acc_t mix_step(input acc_t s, input logic [2:0] step);
        acc_t r;
        r = s;
        case (step)
            3'd0:    r = mix_rd(mix_rc(s, 50), 52);
            3'd1:    r = mix_rb(mix_ra(s, 30), 41);
            3'd2:    r = mix_rd(mix_rc(s, 54), 48);
            3'd3:    r = mix_rb(mix_ra(s, 38), 37);
            3'd4:    r = mix_rd(mix_rc(s, 62), 34);
            3'd5:    r = mix_rb(mix_ra(s, 5), 36);
            default: r = s;
        endcase
        return r;
    endfunction

    // Two rounds of the 11-round end function per step; the last step has one.
    function automatic acc_t end_step(input acc_t s, input logic [2:0] step);
        acc_t r;
        r = s;
        case (step)
            3'd0:    r = end_r1(end_r0(s, 15), 52);
            3'd1:    r = end_r3(end_r2(s, 26), 51);
            3'd2:    r = end_r1(end_r0(s, 28), 9);
            3'd3:    r = end_r3(end_r2(s, 47), 54);
            3'd4:    r = end_r1(end_r0(s, 32), 25);
            3'd5:    r = end_r2(s, 63);
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/ssh128_front.sv
module ssh128_front
    import ssh128_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     push,
    output q_entry_t push_entry,
    input  logic     queue_full
);

    localparam int IDX_BITS = LENGTH_BITS - 3;
    localparam int BLK_BITS = LENGTH_BITS - 5;

    logic [IDX_BITS-1:0]    word_index_reg;
    logic [IDX_BITS-1:0]    word_index_next;
    logic [LENGTH_BITS-1:0] len;
    logic [BLK_BITS-1:0]    blocks;
    logic                   half;
    logic [IDX_BITS-1:0]    rem_words;
    logic [63:0]            byte_mask;
    logic                   accept;
    op_t                    op;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    // Length fields: number of full 32-byte blocks and the 16-byte remainder flag.
    assign len       = item.total_length[LENGTH_BITS-1:0];
    assign blocks    = len[LENGTH_BITS-1:5];
    assign half      = len[4];
    assign rem_words = word_index_reg - {blocks, 2'b00};

    // Keep only the bytes that the valid count covers.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[8*i +: 8] = {8{item.valid_bytes > 4'(i)}};
        end
    end

    // Classify the word by its position within the message.
    always_comb
    begin
        op = OP_NONE;
        if (word_index_reg[IDX_BITS-1:2] < blocks)
        begin
            unique case (word_index_reg[1:0])
                2'd0:    op = OP_ADD_C;
                2'd1:    op = OP_ADD_D_MIX;
                2'd2:    op = OP_ADD_A;
                default: op = OP_ADD_B;
            endcase
        end
        else if (half && (rem_words[IDX_BITS-1:1] == '0))
        begin
            op = rem_words[0] ? OP_ADD_D_MIX : OP_ADD_C;
        end
        else if (rem_words == IDX_BITS'({half, 1'b0}))
        begin
            op = OP_ADD_C;
        end
        else if (rem_words == IDX_BITS'({half, 1'b1}))
        begin
            op = OP_ADD_D;
        end
    end

    // Words that change nothing are dropped unless they close the message.
    assign push                  = accept && ((op != OP_NONE) || item.last_word);
    assign push_entry.op         = op;
    assign push_entry.word       = item.data_word & byte_mask;
    assign push_entry.last       = item.last_word;
    assign push_entry.len_byte   = len[7:0];
    assign push_entry.tail_empty = (len[3:0] == 4'd0);

    // Word counter, cleared after each message.
    always_comb
    begin
        word_index_next = word_index_reg;
        if (accept)
        begin
            word_index_next = item.last_word ? '0 : word_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg <= '0;
        end
        else
        begin
            word_index_reg <= word_index_next;
        end
    end

endmodule

>>> rtl/core/ssh128_queue.sv
module ssh128_queue
    import ssh128_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_entry,
    output logic     empty
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    q_entry_t            slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    assign full      = (count_reg == CNT_BITS'(DEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    // The front end never writes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");

    // The back end never reads from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

>>> rtl/core/ssh128_back.sv
module ssh128_back
    import ssh128_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    output logic      pop,
    input  q_entry_t  pop_entry,
    output logic      hash_valid,
    input  logic      hash_ready,
    output out_item_t hash
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MIX  = 4'b0010,
        S_FIN  = 4'b0100,
        S_END  = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    acc_t        acc_reg;
    acc_t        acc_next;
    acc_t        mix_acc;
    acc_t        end_acc;
    logic        last_reg;
    logic        last_next;
    logic [7:0]  len_byte_reg;
    logic [7:0]  len_byte_next;
    logic        tail_empty_reg;
    logic        tail_empty_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_item_t   out_reg;
    out_item_t   out_next;
    logic        out_free;

    // Combinational round logic for the mix and end functions, one step of each.
    assign mix_acc  = mix_step(acc_reg, step_reg);
    assign end_acc  = end_step(acc_reg, step_reg);
    assign out_free = !out_valid_reg || hash_ready;

    assign hash_valid = out_valid_reg;
    assign hash       = out_reg;

    // Sequencer: absorb a word, run the mix, finalize and emit.
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        acc_next        = acc_reg;
        last_next       = last_reg;
        len_byte_next   = len_byte_reg;
        tail_empty_next = tail_empty_reg;
        out_valid_next  = out_valid_reg && !hash_ready;
        out_next        = out_reg;
        pop             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop             = 1'b1;
                    last_next       = pop_entry.last;
                    len_byte_next   = pop_entry.len_byte;
                    tail_empty_next = pop_entry.tail_empty;
                    step_next       = 3'd0;
                    unique case (pop_entry.op) inside
                        OP_ADD_A:               acc_next.a = acc_reg.a + pop_entry.word;
                        OP_ADD_B:               acc_next.b = acc_reg.b + pop_entry.word;
                        OP_ADD_C:               acc_next.c = acc_reg.c + pop_entry.word;
                        OP_ADD_D, OP_ADD_D_MIX: acc_next.d = acc_reg.d + pop_entry.word;
                        default:                acc_next   = acc_reg;
                    endcase
                    if (pop_entry.op == OP_ADD_D_MIX)
                    begin
                        state_next = S_MIX;
                    end
                    else if (pop_entry.last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_MIX:
            begin
                acc_next = mix_acc;
                if (step_reg == STEP_LAST)
                begin
                    step_next  = 3'd0;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            S_FIN:
            begin
                // Length byte at the top of d, seed again when the tail is empty.
                acc_next.c = acc_reg.c + (tail_empty_reg ? SEED_MAGIC : 64'd0);
                acc_next.d = acc_reg.d + {len_byte_reg + (tail_empty_reg ? SEED_MAGIC[63:56] : 8'd0),
                                          (tail_empty_reg ? SEED_MAGIC[55:0] : 56'd0)};
                step_next  = 3'd0;
                state_next = S_END;
            end

            S_END:
            begin
                if (step_reg != STEP_LAST)
                begin
                    acc_next  = end_acc;
                    step_next = step_reg + 3'd1;
                end
                else if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.hash_low  = end_acc.a;
                    out_next.hash_high = end_acc.b;
                    acc_next           = ACC_RESET;
                    step_next          = 3'd0;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            acc_reg       <= ACC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-message fields and the result register need no reset.
    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        len_byte_reg   <= len_byte_next;
        tail_empty_reg <= tail_empty_next;
        out_reg        <= out_next;
    end

`ifndef SYNTHESIS
    // Finalization always leads into the first end step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (state_reg == S_END) && (step_reg == 3'd0))
        else $error("finalization not followed by end rounds");

    // Leaving the end rounds loads a result and restores the seed state.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && $past(state_reg == S_END))
        |-> out_valid_reg && (acc_reg == ACC_RESET))
        else $error("result not emitted or accumulators not reseeded");

    // The round counter stays within the six steps.
    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= STEP_LAST)
        else $error("round step out of range");
`endif

endmodule

>>> rtl/core/spooky_short_hash128.sv
// A last word is pushed into the word queue, absorbed by the back end, mixed when it is the
// second word of a 32-byte block or of the 16-byte remainder, then finalized and run through
// the end rounds; any backlog waiting in the word queue is handled first. One word per cycle is
// accepted while the queue has room, also while the back end mixes or finalizes; the back end
// absorbs one queued word at a time and runs the mix two rounds a cycle.
// Reset: rst_n (async, active low) reseeds the accumulators and clears counter and queue.
module spooky_short_hash128
    import ssh128_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      hash_valid,
    input  logic      hash_ready,
    output out_item_t hash
);

    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_empty;
    q_entry_t push_entry;
    q_entry_t pop_entry;

    // Front end: word counter and classification.
    ssh128_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    // Decoupling queue between classification and the accumulators.
    ssh128_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty)
    );

    // Back end: accumulators, mix and end rounds, result register.
    ssh128_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (queue_empty),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash       (hash)
    );

endmodule

>>> tb/spooky_short_hash128_test.sv
`timescale 1ns / 100ps

module spooky_short_hash128_test;
    import ssh128_pkg::*;

    localparam int LEN_BITS     = LENGTH_BITS_DEF;
    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 64;

    // How the bytes of a directed message are filled.
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    // Tracks the hash state as words are accepted and holds the hashes still owed.
    class hash_scoreboard;
        logic [63:0]         a;
        logic [63:0]         b;
        logic [63:0]         c;
        logic [63:0]         d;
        logic [LEN_BITS-4:0] word_idx;
        out_item_t           owed_hashes[$];
        int unsigned         n_errors;
        int unsigned         n_checked;

        function new();
            reseed();
            n_errors  = 0;
            n_checked = 0;
        endfunction

        function void reseed();
            a        = 64'd0;
            b        = 64'd0;
            c        = SEED_MAGIC;
            d        = SEED_MAGIC;
            word_idx = '0;
        endfunction

        function logic [63:0] rol(input logic [63:0] x, input int unsigned k);
            return (x << k) | (x >> (64 - k));
        endfunction

        // The twelve-round mix applied after the second word of each 32-byte block and of the 16-byte pair.
        function void mix_rounds();
            c = rol(c, 50); c += d; a ^= c;
            d = rol(d, 52); d += a; b ^= d;
            a = rol(a, 30); a += b; c ^= a;
            b = rol(b, 41); b += c; d ^= b;
            c = rol(c, 54); c += d; a ^= c;
            d = rol(d, 48); d += a; b ^= d;
            a = rol(a, 38); a += b; c ^= a;
            b = rol(b, 37); b += c; d ^= b;
            c = rol(c, 62); c += d; a ^= c;
            d = rol(d, 34); d += a; b ^= d;
            a = rol(a, 5);  a += b; c ^= a;
            b = rol(b, 36); b += c; d ^= b;
        endfunction

        // The eleven end rounds that turn the accumulators into the hash.
        function void end_rounds();
            d ^= c; c = rol(c, 15); d += c;
            a ^= d; d = rol(d, 52); a += d;
            b ^= a; a = rol(a, 26); b += a;
            c ^= b; b = rol(b, 51); c += b;
            d ^= c; c = rol(c, 28); d += c;
            a ^= d; d = rol(d, 9);  a += d;
            b ^= a; a = rol(a, 47); b += a;
            c ^= b; b = rol(b, 54); c += b;
            d ^= c; c = rol(c, 32); d += c;
            a ^= d; d = rol(d, 25); a += d;
            b ^= a; a = rol(a, 63); b += a;
        endfunction

        // Absorbs one accepted word and, on a last word, records the hash it owes.
        function void note_word(in_item_t w);
            logic [63:0] dw;
            logic [63:0] len;
            logic [63:0] off;
            logic [63:0] full;
            logic [63:0] half;
            logic [63:0] r;
            logic [63:0] t;
            out_item_t   h;
            dw = w.data_word;
            if (w.valid_bytes < 4'd8)
                dw &= (64'd1 << {w.valid_bytes, 3'b000}) - 64'd1;
            len  = 64'(w.total_length[LEN_BITS-1:0]);
            off  = 64'(word_idx) << 3;
            full = len & ~64'h1f;
            half = len & 64'h10;

            // Place the word by its offset: full blocks, the 16-byte pair, then the tail.
            if (off < full)
            begin
                case (word_idx[1:0])
                    2'd0: c += dw;
                    2'd1:
                    begin
                        d += dw;
                        mix_rounds();
                    end
                    2'd2: a += dw;
                    default: b += dw;
                endcase
            end
            else
            begin
                r = off - full;
                if (half != 0 && r < 16)
                begin
                    if (r == 0)
                        c += dw;
                    else
                    begin
                        d += dw;
                        mix_rounds();
                    end
                end
                else
                begin
                    t = r - half;
                    if (t == 0)
                        c += dw;
                    else if (t == 8)
                        d += dw;
                end
            end
            word_idx++;

            // Fold in the length byte and finish the hash on the last word.
            if (w.last_word)
            begin
                d += {len[7:0], 56'd0};
                if (len[3:0] == 4'd0)
                begin
                    c += SEED_MAGIC;
                    d += SEED_MAGIC;
                end
                end_rounds();
                h.hash_low  = a;
                h.hash_high = b;
                owed_hashes.push_back(h);
                reseed();
            end
        endfunction

        // Compares a delivered hash with the oldest one owed.
        function void check_hash(out_item_t got);
            out_item_t want;
            if (owed_hashes.size() == 0)
            begin
                $error("unexpected hash transaction: low %h high %h",
                       got.hash_low, got.hash_high);
                n_errors++;
                return;
            end
            want = owed_hashes.pop_front();
            n_checked++;
            if (got.hash_low !== want.hash_low)
            begin
                $error("hash_low: expected %h, actual %h", want.hash_low, got.hash_low);
                n_errors++;
            end
            if (got.hash_high !== want.hash_high)
            begin
                $error("hash_high: expected %h, actual %h", want.hash_high, got.hash_high);
                n_errors++;
            end
        endfunction

        function int unsigned pending();
            return owed_hashes.size();
        endfunction
    endclass

    logic      clk        = 1'b0;
    logic      rst_n      = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item       = '0;
    logic      hash_valid;
    logic      hash_ready = 1'b0;
    out_item_t hash;

    hash_scoreboard board = new();
    int unsigned    idle_pct   = 31;
    int unsigned    words_sent = 0;
    int unsigned    n_messages = 0;
    int unsigned    n_broken   = 0;

    spooky_short_hash128 u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .hash_valid (hash_valid),
        .hash_ready (hash_ready),
        .hash       (hash)
    );

    always #5 clk = ~clk;

    // Observe both channels; every accepted transaction goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
            board.note_word(item);
        if (rst_n && hash_valid && hash_ready)
            board.check_hash(hash);
    end

    // The receiver stalls at random.
    always @(posedge clk)
        hash_ready <= ($urandom_range(99) >= idle_pct);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one word, possibly after an idle gap, and waits until it is taken.
    task automatic send_word(input logic [63:0] data, input logic [3:0] vb,
                             input logic last, input logic [31:0] len);
        in_item_t w;
        w.data_word    = data;
        w.valid_bytes  = vb;
        w.last_word    = last;
        w.total_length = len;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (!item_ready);
        words_sent++;
    endtask

    // Sends a well-formed message of the given length.
    task automatic send_message(input int unsigned len, input fill_t fill);
        int unsigned n;
        logic [63:0] data;
        logic [3:0]  vb;
        n = (len == 0) ? 1 : (len + 7) / 8;
        for (int unsigned i = 0; i < n; i++)
        begin
            case (fill)
                FILL_ZERO: data = '0;
                FILL_ONES: data = '1;
                default:   data = rand64();
            endcase
            if (len == 0)
                vb = 4'd0;
            else if (i == n - 1 && len % 8 != 0)
                vb = 4'(len % 8);
            else
                vb = 4'd8;
            send_word(data, vb, i == n - 1, len);
        end
        n_messages++;
    endtask

    // Sends a malformed message of one of several kinds.
    task automatic send_broken();
        int unsigned n;
        logic [31:0] len;
        case ($urandom_range(3))
            // Random word counts, lengths that may change from word to word.
            0:
            begin
                n   = $urandom_range(1, 6);
                len = $urandom;
                for (int unsigned i = 0; i < n; i++)
                begin
                    if ($urandom_range(1) == 1)
                        len = ($urandom_range(1) == 1) ? $urandom : $urandom_range(0, 80);
                    send_word(rand64(), 4'($urandom_range(0, 8)), i == n - 1, len);
                end
            end
            // Extra words past the tail before the last word.
            1:
            begin
                len = $urandom_range(0, 40);
                n   = (len + 7) / 8 + $urandom_range(1, 3);
                for (int unsigned i = 0; i < n; i++)
                    send_word(rand64(), 4'd8, i == n - 1, len);
            end
            // Last word arrives before the message is complete.
            2:
            begin
                n   = $urandom_range(1, 12);
                len = ($urandom_range(1) == 1) ? 8 * n + $urandom_range(1, 300)
                                               : $urandom | 32'h0000_1000;
                for (int unsigned i = 0; i < n; i++)
                    send_word(rand64(), 4'd8, i == n - 1, len);
            end
            // Valid byte counts that disagree with the length.
            default:
            begin
                len = $urandom_range(1, 100);
                n   = (len + 7) / 8;
                for (int unsigned i = 0; i < n; i++)
                    send_word(rand64(), 4'($urandom_range(0, 8)), i == n - 1, len);
            end
        endcase
        n_broken++;
        n_messages++;
    endtask

    // Holds the sender until every owed hash has been delivered.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned len;
        bit          paused;
        paused = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages: empty, partial words, pairs, blocks and the odd cases.
        send_message(0, FILL_RANDOM);
        send_message(7, FILL_ONES);
        send_message(16, FILL_ONES);
        send_message(31, FILL_RANDOM);
        send_message(32, FILL_RANDOM);
        send_message(40, FILL_ZERO);
        // Last word long before the stated end of a maximal-length message.
        send_word('1, 4'd8, 1'b0, 32'hffff_ffff);
        send_word('1, 4'd8, 1'b1, 32'hffff_ffff);
        // A five-byte message with extra words: the second still goes into d, the third is ignored.
        send_word(rand64(), 4'd5, 1'b0, 32'd5);
        send_word(rand64(), 4'd8, 1'b0, 32'd5);
        send_word(rand64(), 4'd8, 1'b1, 32'd5);
        // Length changes partway through the message.
        send_word(rand64(), 4'd8, 1'b0, 32'd24);
        send_word(rand64(), 4'd8, 1'b0, 32'd20);
        send_word(rand64(), 4'd4, 1'b1, 32'd20);
        // Byte count smaller than the length says.
        send_word('1, 4'd3, 1'b1, 32'd8);
        n_messages += 4;
        n_broken   += 4;
        drain();

        // Random traffic, mostly well-formed, with one stretch of no idling.
        while (words_sent < RANDOM_WORDS)
        begin
            idle_pct = (words_sent >= 800 && words_sent < 1100) ? 0 : 31;
            if (words_sent >= 1300 && !paused)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 75)
            begin
                case ($urandom_range(19))
                    0:       len = $urandom_range(161, 400);
                    1, 2, 3: len = $urandom_range(49, 160);
                    default: len = $urandom_range(0, 48);
                endcase
                send_message(len, FILL_RANDOM);
            end
            else
                send_broken();
        end
        idle_pct = 31;
        drain();

        $display("Sent %0d messages in %0d words, %0d of them malformed or irregular.",
                 n_messages, words_sent, n_broken);
        $display("Compared %0d hashes against the predicted values.", board.n_checked);
        if (board.n_errors == 0)
            $display("spooky_short_hash128_test: clean");
        else
            $display("spooky_short_hash128_test: errors");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #5ms;
        $display("Timed out with %0d hashes still owed.", board.pending());
        $display("spooky_short_hash128_test: errors");
        $finish;
    end

endmodule
